/* design/pts_pkg.sv */
package pts_pkg;

  localparam int unsigned EntryW   = 5;
  localparam int unsigned TimeW    = 24;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned CountW   = 6;

  localparam logic [WaitW-1:0] MaxWaitReset = WaitW'(60);

  // Command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_ACTIVE_COUNT = 1'b0,
    REG_MAX_WAIT     = 1'b1
  } pts_reg_e;

  typedef struct packed {
    logic                command;
    logic [EntryW-1:0]   entry_index;
    logic [TimeW-1:0]    period_sec;
    logic [ElapsedW-1:0] elapsed_sec;
  } pts_in_t;

  typedef struct packed {
    logic              is_wait_report;
    logic [EntryW-1:0] fired_index;
    logic [WaitW-1:0]  next_wait_sec;
    logic              last;
  } pts_out_t;

endpackage

/* design/pts_ram.sv */
module pts_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/periodic_timer_table_scheduler.sv */
// Channel    Direction  Handshake                        Payload
// ---------  ---------  -------------------------------  ---------------------
// command    in         start & !busy accepts a transfer cmd_i (pts_in_t)
// result     out        result_strobe_o, one cycle only   result_o (pts_out_t)
// config     in/out     APB, write at psel&penable&pwrite  pwdata / prdata
//
// A load transfer keeps busy low; the next command may follow at once. A tick
// keeps busy high through the walk and report states (straight to the report
// state when N is zero), N = min(active_count, NUM_TIMERS): the walk visits one
// entry per cycle through the remaining/period RAM read port (registered read
// data), then the report state forms the wait report. Results leave through an
// output register, so the wait report shows in the first cycle with busy low.
// Reset clears control and configuration only; table entries are undefined
// until loaded. The receiver cannot stall, so the walk never pauses.
module periodic_timer_table_scheduler
  import pts_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  pts_in_t     cmd_i,
  // result channel
  output logic        result_strobe_o,
  output pts_out_t    result_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_REPORT = 3'b100
  } pts_state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] active_count_q;
  logic [WaitW-1:0]  max_wait_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      max_wait_q     <= MaxWaitReset;
    end else if (cfg_wr) begin
      case (pts_reg_e'(paddr[2]))
        REG_ACTIVE_COUNT: active_count_q <= pwdata[CountW-1:0];
        REG_MAX_WAIT:     max_wait_q     <= pwdata[WaitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pts_reg_e'(paddr[2]))
      REG_ACTIVE_COUNT: prdata = {{(32-CountW){1'b0}}, active_count_q};
      REG_MAX_WAIT:     prdata = {{(32-WaitW){1'b0}}, max_wait_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  pts_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;       // entries to walk this tick
  logic [CntW-1:0]   rd_q, rd_d;         // next entry to read
  logic              p_vld_q;            // read data valid for p_idx_q
  logic [IdxW-1:0]   p_idx_q;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [WaitW-1:0]  best_q, best_d;     // running minimum, starts at max_wait
  logic              res_vld_q, res_vld_d;
  pts_out_t          res_q, res_d;

  logic              accept;
  logic              load_wr;
  logic              rd_en;
  logic [TimeW-1:0]  rem_rdata;
  logic [TimeW-1:0]  per_rdata;
  logic [TimeW-1:0]  r_sub;
  logic [TimeW-1:0]  r_new;
  logic              fire;
  logic              rem_we;
  logic [IdxW-1:0]   rem_waddr;
  logic [TimeW-1:0]  rem_wdata;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start & ~busy;
  // loads beyond the table are dropped
  assign load_wr = accept & (cmd_i.command == CmdLoad) &
                   (32'(cmd_i.entry_index) < NUM_TIMERS);
  assign rd_en   = (state_q == S_WALK) & (rd_q != cnt_q);

  // update of the entry whose read data arrived this cycle
  assign r_sub = (rem_rdata > TimeW'(elapsed_q)) ? (rem_rdata - TimeW'(elapsed_q)) : '0;
  assign fire  = (r_sub == '0);
  assign r_new = fire ? per_rdata : r_sub;

  // one write port on the remaining table: loads in idle, write-back in walk
  assign rem_we    = load_wr | p_vld_q;
  assign rem_waddr = p_vld_q ? p_idx_q : IdxW'(cmd_i.entry_index);
  assign rem_wdata = p_vld_q ? r_new : '0;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    elapsed_d = elapsed_q;
    best_d    = best_q;
    res_vld_d = 1'b0;
    res_d     = res_q;

    if (p_vld_q) begin
      if (r_new < TimeW'(best_q)) begin
        best_d = r_new[WaitW-1:0];
      end
      if (fire) begin
        res_vld_d            = 1'b1;
        res_d.is_wait_report = 1'b0;
        res_d.fired_index    = EntryW'(p_idx_q);
        res_d.next_wait_sec  = '0;
        res_d.last           = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i.command == CmdTick)) begin
          cnt_d     = (active_count_q > CountW'(NUM_TIMERS)) ?
                      CntW'(NUM_TIMERS) : CntW'(active_count_q);
          rd_d      = '0;
          elapsed_d = cmd_i.elapsed_sec;
          best_d    = max_wait_q;
          state_d   = (cnt_d == '0) ? S_REPORT : S_WALK;
        end
      end
      S_WALK: begin
        if (rd_en) begin
          rd_d = rd_q + CntW'(1);
        end else begin
          // last entry is in the update stage now
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        res_vld_d            = 1'b1;
        res_d.is_wait_report = 1'b1;
        res_d.fired_index    = '0;
        res_d.next_wait_sec  = best_q;
        res_d.last           = 1'b1;
        state_d              = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      p_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      p_vld_q   <= rd_en;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    p_idx_q   <= rd_q[IdxW-1:0];
    elapsed_q <= elapsed_d;
    best_q    <= best_d;
    res_q     <= res_d;
  end

  assign result_strobe_o = res_vld_q;
  assign result_o        = res_q;

  // ---------------------------------------------------------------------------
  // Tables
  // ---------------------------------------------------------------------------
  pts_ram #(
    .Width (TimeW),
    .Depth (NUM_TIMERS)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (load_wr),
    .waddr_i (IdxW'(cmd_i.entry_index)),
    .wdata_i (cmd_i.period_sec),
    .re_i    (rd_en),
    .raddr_i (rd_q[IdxW-1:0]),
    .rdata_o (per_rdata)
  );

  pts_ram #(
    .Width (TimeW),
    .Depth (NUM_TIMERS)
  ) u_remaining_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_q[IdxW-1:0]),
    .rdata_o (rem_rdata)
  );

endmodule

/* design/pts_checker.sv */
module pts_checker
  import pts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input pts_in_t  cmd_i,
  input logic     result_strobe_o,
  input pts_out_t result_o,
  input logic     pready
);

  // A load never occupies the block.
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CmdLoad) |=> !busy && !result_strobe_o)
    else $error("load transfer left the block busy or produced a result");

  // A tick always occupies the block.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CmdTick) |=> busy)
    else $error("tick transfer did not raise busy");

  // The wait report closes the run: it is marked last and busy has dropped.
  a_report_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.is_wait_report) |-> result_o.last && !busy)
    else $error("wait report not last or block still busy");

  // Fired results only appear inside a tick run and carry no wait.
  a_fired_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.is_wait_report) |->
      busy && !result_o.last && result_o.next_wait_sec == '0)
    else $error("fired result outside a run or with bad fields");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind periodic_timer_table_scheduler pts_checker u_pts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .cmd_i           (cmd_i),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o),
  .pready          (pready)
);
